@@ design/swm_pkg.sv @@
// shared types and constants for the sliding window maximum block
`default_nettype none

package swm_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned WIN_W           = 7;
	localparam int unsigned MAX_WINDOW_DEF  = 64;

	// one deque candidate; age is the distance to the next sample position
	typedef struct packed {
		logic                     valid;
		logic signed [DATA_W-1:0] value;
		logic [WIN_W-1:0]         age;
	} entry_t;

	// per-cycle command broadcast from the top level to every cell
	typedef struct packed {
		logic                     accept;
		logic                     drop;
		logic                     shift;
		logic                     last;
		logic signed [DATA_W-1:0] sample;
	} cell_ctl_t;

endpackage

`default_nettype wire

@@ design/swm_cell.sv @@
// one deque slot: dominance check, append decision and neighbor hand-off
`default_nettype none

module swm_cell
	import swm_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire cell_ctl_t ctl,
	input  wire logic      prev_kept,
	input  wire entry_t    up_cur,
	input  wire entry_t    up_nxt,
	output logic           kept,
	output entry_t         cur,
	output entry_t         nxt
);

	logic             valid_q;
	logic signed [DATA_W-1:0] value_q;
	logic [WIN_W-1:0] age_q;
	logic             app;
	entry_t           load;

	assign cur.valid = valid_q;
	assign cur.value = value_q;
	assign cur.age   = age_q;

	// strictly smaller candidates are dominated by the new sample
	assign kept = valid_q && !($signed(value_q) < $signed(ctl.sample));
	// first slot past the kept prefix takes the new sample
	assign app  = !kept && prev_kept;

	always_comb begin
		nxt.valid = kept || app;
		nxt.value = kept ? value_q : ctl.sample;
		nxt.age   = kept ? (age_q + WIN_W'(1)) : WIN_W'(1);
	end

	always_comb begin
		if (ctl.accept) begin
			load = ctl.drop ? up_nxt : nxt;
		end else begin
			load = up_cur;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.accept) begin
			valid_q <= ctl.last ? 1'b0 : load.valid;
		end else if (ctl.shift) begin
			valid_q <= load.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.accept || ctl.shift) begin
			value_q <= load.value;
			age_q   <= load.age;
		end
	end

endmodule

`default_nettype wire

@@ design/sliding_window_maximum.sv @@
// sliding window maximum: top level with a chain of monotonic deque cells
// latency: a result beat is offered in the cycle after its sample beat is accepted
// throughput: one sample per cycle while the window length is steady or grows;
// a result beat left waiting holds off the next sample
// after a shortened window, stale candidates beyond the first retire one at a time while the next
// sample waits (at most the old window length minus the new one); reset: deque empty, fill 0, window 1
`default_nettype none

module sliding_window_maximum
	import swm_pkg::*;
#(
	parameter int unsigned MAX_WINDOW = MAX_WINDOW_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_we,
	input  wire logic [WIN_W-1:0]         cfg_data,
	input  wire logic                     in_valid,
	output logic                          in_ready,
	input  wire logic signed [DATA_W-1:0] sample,
	input  wire logic                     sample_last,
	output logic                          out_valid,
	input  wire logic                     out_ready,
	output logic signed [DATA_W-1:0]      window_max
);

	// the config field is 7 bits, so the usable window never exceeds 127
	localparam int unsigned MAX_EFF = (MAX_WINDOW > ((1 << WIN_W) - 1)) ?
		((1 << WIN_W) - 1) : MAX_WINDOW;
	localparam logic [WIN_W-1:0] MAX_W = WIN_W'(MAX_EFF);
	// one spare cell: a full window may hold a stale head while a sample is appended
	localparam int unsigned NCELL = MAX_WINDOW + 1;

	logic [WIN_W-1:0]         window_size_q;
	logic [WIN_W-1:0]         win_eff;
	logic [WIN_W-1:0]         fill_q;
	logic [WIN_W-1:0]         fill_nxt;
	logic                     out_valid_q;
	logic signed [DATA_W-1:0] window_max_q;
	logic                     head_stale;
	logic                     stall;
	logic                     accept;
	logic                     emit;
	cell_ctl_t                ctl;

	// chain wiring; index NCELL is the empty slot past the last cell
	entry_t cur_a  [0:NCELL];
	entry_t nxt_a  [0:NCELL];
	logic   kept_a [0:NCELL];

	// window length register, zero reads as one, clamped to MAX_WINDOW and to 127
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_size_q <= WIN_W'(1);
		end else if (cfg_we) begin
			window_size_q <= cfg_data;
		end
	end

	always_comb begin
		if (window_size_q == '0) begin
			win_eff = WIN_W'(1);
		end else if (window_size_q > MAX_W) begin
			win_eff = MAX_W;
		end else begin
			win_eff = window_size_q;
		end
	end

	// head candidate is a full window old: it leaves together with the next sample
	assign head_stale = cur_a[0].valid && (cur_a[0].age >= win_eff);
	// a second stale candidate behind it: retire the head first, one per cycle while a sample waits
	assign stall      = head_stale && cur_a[1].valid && (cur_a[1].age >= win_eff);
	assign in_ready   = !stall && (!out_valid_q || out_ready);
	assign accept     = in_valid && in_ready;

	// fill count clamps to the window, then counts this sample
	assign fill_nxt = (fill_q >= win_eff) ? win_eff : (fill_q + WIN_W'(1));
	assign emit     = (fill_nxt == win_eff);

	always_comb begin
		ctl.accept = accept;
		// stale head drops out while the sample is appended behind the rest
		ctl.drop   = head_stale;
		// retire only with a sample waiting, so the window in use is the one it sees
		ctl.shift  = stall && in_valid;
		ctl.last   = sample_last;
		ctl.sample = sample;
	end

	assign kept_a[0]     = 1'b1;
	assign cur_a[NCELL]  = '0;
	assign nxt_a[NCELL]  = '0;

	for (genvar i = 0; i < NCELL; i++) begin : g_cell
		logic kept_i;

		swm_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.prev_kept (kept_a[i]),
			.up_cur    (cur_a[i+1]),
			.up_nxt    (nxt_a[i+1]),
			.kept      (kept_i),
			.cur       (cur_a[i]),
			.nxt       (nxt_a[i])
		);

		// a stale head counts as kept for its successor, so the sample lands past it
		if (i == 0) begin : g_head
			assign kept_a[1] = kept_i || head_stale;
		end else begin : g_link
			assign kept_a[i+1] = kept_i;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
		end else if (accept) begin
			fill_q <= sample_last ? '0 : fill_nxt;
		end
	end

	// output register: a new result beat replaces one taken in the same cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// the head after append is the window maximum; past a stale head it is cell 1
	always_ff @(posedge clk) begin
		if (accept && emit) begin
			window_max_q <= head_stale ? nxt_a[1].value : nxt_a[0].value;
		end
	end

	assign out_valid  = out_valid_q;
	assign window_max = window_max_q;

endmodule

`default_nettype wire

@@ dv/tb_sliding_window_maximum.sv @@
// testbench for the sliding window maximum block: random and directed samples vs a deque model
`default_nettype none

module tb_sliding_window_maximum;
	import swm_pkg::*;

	localparam int DEPTH       = 64;    // deque depth, matches the block's default
	localparam int QUIET_LIMIT = 2000;  // cycles with no beat on any port before giving up
	localparam int HOLD_CYCLES = 300;   // length of the long receiver hold-off
	localparam int TOTAL_BEATS = 1800;
	localparam int CALM_BEATS  = 200;   // one sequence at full window with no idling

	// sample value styles
	typedef enum int {
		STYLE_FULL,
		STYLE_NARROW,
		STYLE_EXTREME,
		STYLE_FALLING,
		STYLE_RISING,
		STYLE_COUNT
	} value_style_e;

	typedef struct {
		logic signed [DATA_W-1:0] value;
		logic                     last;
	} sample_beat_t;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     cfg_we = 1'b0;
	logic [WIN_W-1:0]         cfg_data = '0;
	logic                     in_valid = 1'b0;
	logic                     in_ready;
	logic signed [DATA_W-1:0] sample = '0;
	logic                     sample_last = 1'b0;
	logic                     out_valid;
	logic                     out_ready = 1'b0;
	logic signed [DATA_W-1:0] window_max;

	sliding_window_maximum dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.sample     (sample),
		.sample_last(sample_last),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.window_max (window_max)
	);

	always #6 clk = ~clk;

	// samples waiting to be offered, filled by the stimulus sequence below
	sample_beat_t             pending[$];
	// window maxima still owed by the block, oldest first
	logic signed [DATA_W-1:0] expected_max[$];

	int  error_count = 0;
	int  beats_queued = 0;
	bit  calm = 1'b0;       // no idling on either side while set
	bit  stall_req = 1'b0;  // asks the receiver for one long hold-off
	bit  stall_taken = 1'b0;
	int  hold_left = 0;
	int  quiet_cycles = 0;

	// shadow of the block's deque and counters
	logic signed [DATA_W-1:0] cand_val[DEPTH];
	logic [15:0]              cand_pos[DEPTH];
	logic [5:0]               dq_head = '0;
	int                       dq_count = 0;
	logic [15:0]              next_pos = '0;
	int                       seen_count = 0;
	logic [WIN_W-1:0]         win_setting = 7'd1;

	task automatic note_error(input string msg);
		$display("ERROR at %0t: %s", $realtime, msg);
		error_count++;
	endtask

	// advance the shadow deque by one sample and queue the window max it yields
	task automatic track_window_max(input logic signed [DATA_W-1:0] x, input logic last);
		int          w;
		logic [15:0] age;
		logic [5:0]  idx;
		// zero acts as one, anything past the deque depth as the full depth
		w = (win_setting == 0) ? 1 : ((win_setting > DEPTH) ? DEPTH : int'(win_setting));
		// retire candidates that have aged out of the window, ages modulo 2^16
		while (dq_count > 0) begin
			age = next_pos - cand_pos[dq_head];
			if (age < w)
				break;
			dq_head = dq_head + 1'b1;
			dq_count--;
		end
		// strictly smaller tail candidates can never be the max again; equal ones stay
		while (dq_count > 0) begin
			idx = dq_head + 6'(dq_count - 1);
			if (cand_val[idx] >= x)
				break;
			dq_count--;
		end
		if (dq_count >= DEPTH) begin
			dq_head = dq_head + 1'b1;
			dq_count--;
		end
		idx = dq_head + 6'(dq_count);
		cand_val[idx] = x;
		cand_pos[idx] = next_pos;
		dq_count++;
		next_pos = next_pos + 1'b1;
		// fill count is clamped first, so a shortened window counts as already full
		if (seen_count > w)
			seen_count = w;
		if (seen_count < w)
			seen_count++;
		if (seen_count >= w)
			expected_max.insert(expected_max.size(), cand_val[dq_head]);
		// end of sequence: start over, window setting kept
		if (last) begin
			dq_head = '0;
			dq_count = 0;
			next_pos = '0;
			seen_count = 0;
		end
	endtask

	// input driver: predicts on every accepted beat, then offers the next one
	always @(posedge clk) begin : drive_samples
		sample_beat_t beat;
		bit           gap;
		if (arst_n) begin
			if (cfg_we)
				win_setting = cfg_data;
			if (in_valid && in_ready)
				track_window_max(sample, sample_last);
			// a beat still waiting for ready stays put with its payload
			if (!in_valid || in_ready) begin
				gap = !calm && ($urandom_range(0, 99) < 25);
				if (pending.size() != 0 && !gap) begin
					beat = pending[0];
					pending.delete(0);
					in_valid <= 1'b1;
					sample <= beat.value;
					sample_last <= beat.last;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// result monitor and receiver ready, with one long hold-off on request
	always @(posedge clk) begin : watch_results
		logic signed [DATA_W-1:0] want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_max.size() == 0) begin
					note_error($sformatf("window_max %0d with no result owed", window_max));
				end else begin
					want = expected_max[0];
					expected_max.delete(0);
					if (window_max !== want)
						note_error($sformatf("window_max %0d, want %0d", window_max, want));
				end
			end
			if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				out_ready <= 1'b0;
			end else if (stall_req && !stall_taken) begin
				// sender keeps offering meanwhile, so the block has to back up
				stall_taken <= 1'b1;
				hold_left <= HOLD_CYCLES;
				out_ready <= 1'b0;
			end else begin
				out_ready <= calm || ($urandom_range(0, 99) >= 25);
			end
		end
	end

	// watchdog: any beat or register write counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no beat for %0d cycles", QUIET_LIMIT);
				$display("tb_sliding_window_maximum: done, errors");
				$finish;
			end
		end
	end

	function automatic logic signed [DATA_W-1:0] pick_value(input int style, input int k,
			input logic signed [DATA_W-1:0] base);
		logic signed [DATA_W-1:0] v;
		case (style)
			STYLE_NARROW: begin
				v = int'($urandom_range(0, 6)) - 3;
			end
			STYLE_EXTREME: begin
				case ($urandom_range(0, 5))
					0: v = 32'sh8000_0000;
					1: v = 32'sh7fff_ffff;
					2: v = 32'sh8000_0001;
					3: v = 32'sh7fff_fffe;
					4: v = -1;
					default: v = 0;
				endcase
			end
			STYLE_FALLING: begin
				v = base - k * int'($urandom_range(0, 3));
			end
			STYLE_RISING: begin
				v = base + k * int'($urandom_range(0, 3));
			end
			default: begin
				v = $urandom;
			end
		endcase
		return v;
	endfunction

	task automatic queue_beat(input logic signed [DATA_W-1:0] v, input logic last);
		sample_beat_t beat;
		beat.value = v;
		beat.last = last;
		pending.insert(pending.size(), beat);
		beats_queued++;
	endtask

	// one sequence of len samples; close marks the final one as last
	task automatic queue_sequence(input int len, input int style, input bit close);
		logic signed [DATA_W-1:0] base;
		base = $urandom;
		for (int k = 0; k < len; k++)
			queue_beat(pick_value(style, k, base), close && (k == len - 1));
	endtask

	// wait until everything sent has been answered, then let the block go quiet
	task automatic settle();
		while (pending.size() != 0 || in_valid || expected_max.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	// register write, only ever called with the block idle
	task automatic set_window(input logic [WIN_W-1:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	initial begin
		int w;
		int len;
		int nseq;
		int pick;
		bit close;
		for (int i = 0; i < DEPTH; i++) begin
			cand_val[i] = '0;
			cand_pos[i] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset window of one: every sample is its own max, field extremes
		queue_beat(32'sh8000_0000, 1'b0);
		queue_beat(32'sh7fff_ffff, 1'b0);
		queue_beat(0, 1'b0);
		queue_beat(-1, 1'b1);
		settle();

		// window of three: equal samples kept, falling run, new max flushes the deque
		set_window(7'd3);
		queue_beat(5, 1'b0);
		queue_beat(5, 1'b0);
		queue_beat(5, 1'b0);
		queue_beat(-3, 1'b0);
		queue_beat(-7, 1'b0);
		queue_beat(-9, 1'b0);
		queue_beat(10, 1'b0);
		queue_beat(4, 1'b1);
		settle();

		// zero written to the register behaves as a window of one
		set_window(7'd0);
		queue_beat(7, 1'b0);
		queue_beat(-7, 1'b1);
		settle();

		// sequence shorter than the window yields nothing
		set_window(7'd4);
		queue_beat(1, 1'b0);
		queue_beat(2, 1'b1);
		// open sequence, then shrink and regrow the window in the middle of it
		queue_beat(9, 1'b0);
		queue_beat(8, 1'b0);
		queue_beat(7, 1'b0);
		settle();
		set_window(7'd2);
		queue_beat(6, 1'b0);
		settle();
		set_window(7'd5);
		queue_beat(3, 1'b0);
		queue_beat(1, 1'b1);
		settle();

		// random phases: a window setting, then a few sequences; some left open
		// so the next setting lands mid-sequence
		while (beats_queued < TOTAL_BEATS - CALM_BEATS) begin
			pick = $urandom_range(0, 19);
			case (pick)
				0: set_window(7'd0);
				1: set_window(7'd64);
				2: set_window(7'd65);
				3: set_window(7'd127);
				4, 5, 6: set_window(7'($urandom_range(1, 64)));
				default: set_window(7'($urandom_range(1, 8)));
			endcase
			w = (win_setting == 0) ? 1 : ((win_setting > DEPTH) ? DEPTH : int'(win_setting));
			// long hold-off on the result side once, partway through
			if (beats_queued > 600 && !stall_req)
				stall_req = 1'b1;
			nseq = $urandom_range(1, 3);
			for (int s = 0; s < nseq; s++) begin
				if ($urandom_range(0, 4) == 0)
					len = $urandom_range(1, w);
				else
					len = w + $urandom_range(0, 12);
				close = ($urandom_range(0, 3) != 0) || (s != nseq - 1);
				queue_sequence(len, $urandom_range(0, STYLE_COUNT - 1), close);
			end
			settle();
		end

		// one long sequence at full window with no idling on either side
		set_window(7'd64);
		calm = 1'b1;
		for (int k = 0; k < CALM_BEATS; k++) begin
			if ($urandom_range(0, 15) == 0)
				queue_beat($urandom, k == CALM_BEATS - 1);
			else
				queue_beat(int'($urandom_range(0, 200)) - 100, k == CALM_BEATS - 1);
		end
		settle();
		calm = 1'b0;

		repeat (8) @(posedge clk);
		if (error_count == 0)
			$display("tb_sliding_window_maximum: done, clean");
		else
			$display("tb_sliding_window_maximum: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
